// ===== rtl/core/bse_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Burning Ship escape-time core: shared definitions
// Field widths, register indexes, beat payload types and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package bse_pkg;

	localparam int COORD_BITS_DEF = 36;
	localparam int FRAC_BITS_DEF  = 28;

	localparam int IDX_W     = 12;
	localparam int ITER_W    = 16;
	localparam int RAD_W     = 3;
	localparam int PIX_W     = 8;
	localparam int CFG_IDX_W = 3;

	// Squares and the cross term are capped at 2^61, so they fit in 62 bits.
	localparam int SQ_CAP_LOG2 = 61;
	localparam int SQ_W        = SQ_CAP_LOG2 + 1;

	// Reset point spacing is 1/256 of a unit.
	localparam int STEP_RST_LOG2 = 8;
	localparam logic [RAD_W-1:0]  RADIUS_RST = 3'd2;
	localparam logic [ITER_W-1:0] ITERS_RST  = 16'd256;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_X_MIN     = 3'd0,
		REG_Y_MIN     = 3'd1,
		REG_STEP_X    = 3'd2,
		REG_STEP_Y    = 3'd3,
		REG_RADIUS    = 3'd4,
		REG_MAX_ITERS = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [IDX_W-1:0] col;
		logic [IDX_W-1:0] row;
	} req_t;

	typedef struct packed {
		logic [PIX_W-1:0]  pixel;
		logic [ITER_W-1:0] escape_count;
		logic              escaped;
	} rsp_t;

	typedef struct packed {
		logic       coord_mul;
		logic       coord_load;
		logic       mag_load;
		logic       mul_en;
		logic [1:0] mul_phase;
		logic       acc_clear;
		logic       acc_add;
		logic       scale_en;
		logic       step_en;
		logic       div_init;
		logic       div_step;
		logic       rsp_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic max_zero;
		logic escape;
		logic last_iter;
	} dp_sts_t;

endpackage

// ===== rtl/core/burning_ship_escape_time_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Burning Ship escape-time core
// Maps a pixel to a point, runs the Burning Ship orbit in signed fixed point
// and returns the escape count, an escaped flag and a grey level.
// ----------------------------------------------------------------------------
// One pixel is worked at a time. Each round of the orbit takes the squares
// and the cross term from half-width multipliers that form four partial
// products in turn, and the grey level comes from a one-bit-per-cycle divider.
// The number of rounds evaluated is escape_count, plus one when the point
// escaped. The result sits in an output register, so the next pixel is taken
// while the previous result beat waits to be collected. A finished pixel then
// holds until that register is free, so output stall on the earlier beat
// delays it.
// ----------------------------------------------------------------------------
module burning_ship_escape_time_core import bse_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  req_t                  req,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output rsp_t                  rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [COORD_BITS-1:0] cfg_data
);

	localparam logic [COORD_BITS-1:0] COORD_RST = COORD_BITS'(0) - (COORD_BITS'(2) << FRAC_BITS);
	localparam logic [COORD_BITS-2:0] STEP_RST  = (COORD_BITS - 1)'(1) << (FRAC_BITS - STEP_RST_LOG2);

	logic signed [COORD_BITS-1:0] x_min_q;
	logic signed [COORD_BITS-1:0] y_min_q;
	logic [COORD_BITS-2:0]        step_x_q;
	logic [COORD_BITS-2:0]        step_y_q;
	logic [RAD_W-1:0]             radius_q;
	logic [ITER_W-1:0]            max_iters_q;
	ctl_cmd_t                     cmd;
	dp_sts_t                      sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_min_q     <= COORD_RST;
			y_min_q     <= COORD_RST;
			step_x_q    <= STEP_RST;
			step_y_q    <= STEP_RST;
			radius_q    <= RADIUS_RST;
			max_iters_q <= ITERS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_X_MIN:     x_min_q     <= cfg_data;
				REG_Y_MIN:     y_min_q     <= cfg_data;
				REG_STEP_X:    step_x_q    <= cfg_data[COORD_BITS-2:0];
				REG_STEP_Y:    step_y_q    <= cfg_data[COORD_BITS-2:0];
				REG_RADIUS:    radius_q    <= cfg_data[RAD_W-1:0];
				REG_MAX_ITERS: max_iters_q <= cfg_data[ITER_W-1:0];
				default: ;
			endcase
		end
	end

	bse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	bse_dp #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk           (clk),
		.req           (req),
		.x_min         (x_min_q),
		.y_min         (y_min_q),
		.step_x        (step_x_q),
		.step_y        (step_y_q),
		.escape_radius (radius_q),
		.max_iters     (max_iters_q),
		.cmd           (cmd),
		.sts           (sts),
		.rsp           (rsp)
	);

endmodule

// ===== rtl/core/bse_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Split multiplier
// Forms the full product of two unsigned operands from four half-width
// partial products, one per cycle while en is high, registered and then added.
// ----------------------------------------------------------------------------
module bse_mul import bse_pkg::*; #(
	parameter int HALF = (COORD_BITS_DEF + 1) / 2
) (
	input  logic                clk,
	input  logic                en,
	input  logic                clear,
	input  logic                add,
	input  logic [1:0]          phase,
	input  logic [2*HALF-1:0]   a,
	input  logic [2*HALF-1:0]   b,
	output logic [4*HALF-1:0]   acc
);

	localparam int OPW = 2 * HALF;

	logic [HALF-1:0]   a_half;
	logic [HALF-1:0]   b_half;
	logic [OPW-1:0]    pp_q;
	logic [1:0]        sh_q;
	logic [2*OPW-1:0]  term;
	logic [2*OPW-1:0]  acc_q;

	always_comb begin
		a_half = phase[1] ? a[OPW-1:HALF] : a[HALF-1:0];
		b_half = phase[0] ? b[OPW-1:HALF] : b[HALF-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pp_q <= OPW'(a_half) * OPW'(b_half);
			sh_q <= {1'b0, phase[1]} + {1'b0, phase[0]};
		end
	end

	// The partial product lands at 0, HALF or 2*HALF bits up.
	always_comb begin
		case (sh_q)
			2'd0:    term = {{OPW{1'b0}}, pp_q};
			2'd1:    term = {{HALF{1'b0}}, pp_q, {HALF{1'b0}}};
			2'd2:    term = {pp_q, {OPW{1'b0}}};
			default: term = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (clear) begin
			acc_q <= '0;
		end else if (add) begin
			acc_q <= acc_q + term;
		end
	end

	assign acc = acc_q;

endmodule

// ===== rtl/core/bse_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grey-level divider
// Restoring division of count*255 by the iteration limit, one quotient bit
// per cycle while stepping. The quotient is known to fit in eight bits.
// ----------------------------------------------------------------------------
module bse_div import bse_pkg::*; (
	input  logic                    clk,
	input  logic                    init,
	input  logic                    step,
	input  logic [ITER_W+PIX_W-1:0] num,
	input  logic [ITER_W-1:0]       den,
	output logic [PIX_W-1:0]        quot
);

	localparam int NUMW = ITER_W + PIX_W;

	logic [ITER_W-1:0] rem_q;
	logic [PIX_W-1:0]  bits_q;
	logic [ITER_W:0]   trial;
	logic              fits;

	always_comb begin
		trial = {rem_q, bits_q[PIX_W-1]};
		fits  = trial >= {1'b0, den};
	end

	// Dividend bits shift out at the top while quotient bits shift in below.
	// With a zero limit the count is zero too, and every step fits, giving 255.
	always_ff @(posedge clk) begin
		if (init) begin
			rem_q  <= num[NUMW-1:PIX_W];
			bits_q <= num[PIX_W-1:0];
		end else if (step) begin
			rem_q  <= fits ? ITER_W'(trial - {1'b0, den}) : trial[ITER_W-1:0];
			bits_q <= {bits_q[PIX_W-2:0], fits};
		end
	end

	assign quot = bits_q;

endmodule

// ===== rtl/core/bse_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Burning Ship datapath
// Point setup, the magnitude squares and cross term, escape test, orbit
// update, the grey-level divider and the result register.
// ----------------------------------------------------------------------------
module bse_dp import bse_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  req_t                         req,
	input  logic signed [COORD_BITS-1:0] x_min,
	input  logic signed [COORD_BITS-1:0] y_min,
	input  logic [COORD_BITS-2:0]        step_x,
	input  logic [COORD_BITS-2:0]        step_y,
	input  logic [RAD_W-1:0]             escape_radius,
	input  logic [ITER_W-1:0]            max_iters,
	input  ctl_cmd_t                     cmd,
	output dp_sts_t                      sts,
	output rsp_t                         rsp
);

	localparam int HALF = (COORD_BITS + 1) / 2;
	localparam int OPW  = 2 * HALF;
	localparam int ACCW = 4 * HALF;
	localparam int XW   = (ACCW > 64) ? ACCW : 64;
	localparam int PW   = IDX_W + COORD_BITS - 1;
	localparam int RRW  = 2 * RAD_W;
	localparam int SUMW = SQ_W + 1;
	localparam int CNTW = ITER_W + 1;
	localparam int NUMW = ITER_W + PIX_W;

	localparam logic [PW-1:0]       PLIM   = PW'(1) << COORD_BITS;
	localparam logic signed [63:0]  CMAX   = (64'sd1 <<< (COORD_BITS - 1)) - 64'sd1;
	localparam logic signed [63:0]  CMIN   = -CMAX - 64'sd1;
	localparam logic [XW-1:0]       SQ_CAP = XW'(1) << SQ_CAP_LOG2;

	function automatic logic signed [COORD_BITS-1:0] sat_coord(input logic signed [63:0] v);
		logic signed [COORD_BITS-1:0] r;
		if (v > CMAX) begin
			r = CMAX[COORD_BITS-1:0];
		end else if (v < CMIN) begin
			r = CMIN[COORD_BITS-1:0];
		end else begin
			r = v[COORD_BITS-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [COORD_BITS-1:0] coord(
		input logic signed [COORD_BITS-1:0] base,
		input logic [PW-1:0]                p
	);
		logic [PW-1:0] pc;
		pc = (p > PLIM) ? PLIM : p;
		return sat_coord(64'(base) + $signed(64'(pc)));
	endfunction

	function automatic logic [COORD_BITS-1:0] mag(input logic signed [COORD_BITS-1:0] v);
		logic [COORD_BITS-1:0] u;
		u = v;
		if (v[COORD_BITS-1]) begin
			u = ~u + COORD_BITS'(1);
		end
		return u;
	endfunction

	function automatic logic [SQ_W-1:0] cap_shift(input logic [ACCW-1:0] p, input int unsigned s);
		logic [XW-1:0] w;
		w = XW'(p) >> s;
		if (w > SQ_CAP) begin
			w = SQ_CAP;
		end
		return w[SQ_W-1:0];
	endfunction

	logic [PW-1:0]                px_q;
	logic [PW-1:0]                py_q;
	logic signed [COORD_BITS-1:0] cx_n;
	logic signed [COORD_BITS-1:0] cy_n;
	logic signed [COORD_BITS-1:0] cx_q;
	logic signed [COORD_BITS-1:0] cy_q;
	logic signed [COORD_BITS-1:0] zx_q;
	logic signed [COORD_BITS-1:0] zy_q;
	logic [COORD_BITS-1:0]        ax_q;
	logic [COORD_BITS-1:0]        ay_q;
	logic [ACCW-1:0]              acc_x;
	logic [ACCW-1:0]              acc_y;
	logic [ACCW-1:0]              acc_c;
	logic [SQ_W-1:0]              sx_q;
	logic [SQ_W-1:0]              sy_q;
	logic [SQ_W-1:0]              cr_q;
	logic [RRW-1:0]               rr;
	logic [SUMW-1:0]              limit;
	logic [SUMW-1:0]              mag_sum;
	logic                         escape;
	logic signed [COORD_BITS-1:0] zx_n;
	logic signed [COORD_BITS-1:0] zy_n;
	logic [ITER_W-1:0]            count_q;
	logic                         esc_q;
	logic [NUMW-1:0]              num;
	logic [PIX_W-1:0]             quot;
	rsp_t                         rsp_q;

	// Point setup: index times step on the accept beat, offset and clamp next.
	always_ff @(posedge clk) begin
		if (cmd.coord_mul) begin
			px_q <= PW'(req.col) * PW'(step_x);
			py_q <= PW'(req.row) * PW'(step_y);
		end
	end

	always_comb begin
		cx_n = coord(x_min, px_q);
		cy_n = coord(y_min, py_q);
	end

	// Only the magnitudes of the orbit feed the next round.
	always_ff @(posedge clk) begin
		if (cmd.mag_load) begin
			ax_q <= mag(zx_q);
			ay_q <= mag(zy_q);
		end
	end

	bse_mul #(.HALF(HALF)) u_mul_x (
		.clk   (clk),
		.en    (cmd.mul_en),
		.clear (cmd.acc_clear),
		.add   (cmd.acc_add),
		.phase (cmd.mul_phase),
		.a     (OPW'(ax_q)),
		.b     (OPW'(ax_q)),
		.acc   (acc_x)
	);

	bse_mul #(.HALF(HALF)) u_mul_y (
		.clk   (clk),
		.en    (cmd.mul_en),
		.clear (cmd.acc_clear),
		.add   (cmd.acc_add),
		.phase (cmd.mul_phase),
		.a     (OPW'(ay_q)),
		.b     (OPW'(ay_q)),
		.acc   (acc_y)
	);

	bse_mul #(.HALF(HALF)) u_mul_c (
		.clk   (clk),
		.en    (cmd.mul_en),
		.clear (cmd.acc_clear),
		.add   (cmd.acc_add),
		.phase (cmd.mul_phase),
		.a     (OPW'(ax_q)),
		.b     (OPW'(ay_q)),
		.acc   (acc_c)
	);

	// The cross term keeps one more fraction bit, which doubles it.
	always_ff @(posedge clk) begin
		if (cmd.scale_en) begin
			sx_q <= cap_shift(acc_x, FRAC_BITS);
			sy_q <= cap_shift(acc_y, FRAC_BITS);
			cr_q <= cap_shift(acc_c, FRAC_BITS - 1);
		end
	end

	always_comb begin
		rr      = RRW'(escape_radius) * RRW'(escape_radius);
		limit   = SUMW'(rr) << FRAC_BITS;
		mag_sum = {1'b0, sx_q} + {1'b0, sy_q};
		escape  = mag_sum > limit;
		zx_n    = sat_coord($signed(64'(sx_q)) - $signed(64'(sy_q)) + 64'(cx_q));
		zy_n    = sat_coord($signed(64'(cr_q)) + 64'(cy_q));
	end

	always_ff @(posedge clk) begin
		if (cmd.coord_load) begin
			cx_q    <= cx_n;
			cy_q    <= cy_n;
			zx_q    <= cx_n;
			zy_q    <= cy_n;
			count_q <= '0;
			esc_q   <= 1'b0;
		end else if (cmd.step_en) begin
			esc_q <= escape;
			if (!escape) begin
				zx_q    <= zx_n;
				zy_q    <= zy_n;
				count_q <= count_q + ITER_W'(1);
			end
		end
	end

	always_comb begin
		sts.max_zero  = max_iters == '0;
		sts.escape    = escape;
		sts.last_iter = ({1'b0, count_q} + CNTW'(1)) == {1'b0, max_iters};
		num           = {count_q, {PIX_W{1'b0}}} - NUMW'(count_q);
	end

	bse_div u_div (
		.clk  (clk),
		.init (cmd.div_init),
		.step (cmd.div_step),
		.num  (num),
		.den  (max_iters),
		.quot (quot)
	);

	always_ff @(posedge clk) begin
		if (cmd.rsp_load) begin
			rsp_q.pixel        <= quot;
			rsp_q.escape_count <= count_q;
			rsp_q.escaped      <= esc_q;
		end
	end

	assign rsp = rsp_q;

endmodule

// ===== rtl/core/bse_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Burning Ship controller
// Sequences point setup, the rounds of the orbit, the grey-level division
// and the hand-off of each result beat to the output register.
// ----------------------------------------------------------------------------
module bse_ctrl import bse_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output ctl_cmd_t cmd,
	input  dp_sts_t  sts
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLOAD,
		S_MAG,
		S_MUL,
		S_ACC,
		S_SCALE,
		S_STEP,
		S_DINIT,
		S_DIV,
		S_DONE
	} state_t;

	localparam logic [2:0] MUL_LAST = 3'd3;
	localparam logic [2:0] DIV_LAST = 3'(PIX_W - 1);

	state_t     state_q;
	logic [2:0] cnt_q;
	logic       rsp_valid_q;
	logic       rsp_free;

	assign rsp_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// In the last state a freed output register is refilled below.
			if (rsp_valid_q && !rsp_stall && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_CLOAD;
					end
				end
				S_CLOAD: begin
					state_q <= sts.max_zero ? S_DINIT : S_MAG;
				end
				S_MAG: begin
					cnt_q   <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == MUL_LAST) begin
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					state_q <= S_SCALE;
				end
				S_SCALE: begin
					state_q <= S_STEP;
				end
				S_STEP: begin
					state_q <= (sts.escape || sts.last_iter) ? S_DINIT : S_MAG;
				end
				S_DINIT: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == DIV_LAST) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (rsp_free) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE:  cmd.coord_mul = req_valid;
			S_CLOAD: cmd.coord_load = 1'b1;
			S_MAG:   cmd.mag_load = 1'b1;
			S_MUL: begin
				cmd.mul_en    = 1'b1;
				cmd.mul_phase = cnt_q[1:0];
				cmd.acc_clear = cnt_q == '0;
				cmd.acc_add   = cnt_q != '0;
			end
			S_ACC:   cmd.acc_add = 1'b1;
			S_SCALE: cmd.scale_en = 1'b1;
			S_STEP:  cmd.step_en = 1'b1;
			S_DINIT: cmd.div_init = 1'b1;
			S_DIV:   cmd.div_step = 1'b1;
			S_DONE:  cmd.rsp_load = rsp_free;
			default: cmd = '0;
		endcase
	end

	assign req_stall = state_q != S_IDLE;
	assign rsp_valid = rsp_valid_q;

`ifndef SYNTHESIS
	a_rsp_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == S_DONE)
		else $error("result beat raised without a finished pixel");

	a_acc_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ACC |-> ($past(state_q) == S_MUL && $past(cnt_q) == MUL_LAST))
		else $error("accumulate entered before all partial products");

	a_div_entry: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DINIT |-> ($past(state_q) == S_STEP || $past(state_q) == S_CLOAD))
		else $error("division started outside an orbit exit");

	a_setup_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLOAD |-> $past(req_valid && !req_stall))
		else $error("point setup without an accepted beat");
`endif

endmodule

// ===== dv/tb_burning_ship_escape_time_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Burning Ship escape-time core testbench
// Sends pixel beats under a range of view, radius and round-limit settings.
// Each accepted pixel is predicted with an orbit model kept in the bench, and
// every result beat is compared field by field with the oldest prediction.
// The request side idles and the result side stalls in random bursts.
// ----------------------------------------------------------------------------
module tb_burning_ship_escape_time_core import bse_pkg::*; ();

	localparam int CW = COORD_BITS_DEF;
	localparam int FW = FRAC_BITS_DEF;
	localparam longint C_MAX = (longint'(1) << (CW - 1)) - 1;
	localparam longint C_MIN = -C_MAX - 1;
	localparam longint unsigned SPAN_CAP = 64'd1 << CW;
	localparam longint unsigned PROD_CAP = 64'd1 << SQ_CAP_LOG2;
	localparam longint UNIT = longint'(1) << FW;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req_beat = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp_beat;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_X_MIN;
	logic [CW-1:0] cfg_data = '0;

	// Register image used for prediction, starting from the reset values.
	logic signed [CW-1:0] view_x0 = CW'(-(2 * UNIT));
	logic signed [CW-1:0] view_y0 = CW'(-(2 * UNIT));
	logic [CW-2:0] pitch_x = (CW - 1)'(1) << (FW - STEP_RST_LOG2);
	logic [CW-2:0] pitch_y = (CW - 1)'(1) << (FW - STEP_RST_LOG2);
	logic [RAD_W-1:0] radius_q = RADIUS_RST;
	logic [ITER_W-1:0] round_limit = ITERS_RST;

	rsp_t shades_due[$];
	rsp_t oldest;
	logic idle_on = 1'b1;
	int stall_left = 0;
	int errors = 0;
	int n_shaded = 0;
	int n_escaped = 0;
	int n_capped = 0;
	int n_settings = 0;

	burning_ship_escape_time_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req_beat),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp_beat),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#100_000_000;
		$display("%0t: timeout with %0d results outstanding", $time, shades_due.size());
		$display("Simulation FAILED");
		$finish;
	end

	function automatic longint clamp_coord(input longint v);
		if (v > C_MAX) return C_MAX;
		if (v < C_MIN) return C_MIN;
		return v;
	endfunction

	function automatic longint unsigned magnitude(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	// Floor of a*b / 2^sh, held at the product cap.
	function automatic longint unsigned scaled_product(input longint unsigned a,
			input longint unsigned b, input int sh);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		p = p >> sh;
		return (p > PROD_CAP) ? PROD_CAP : p[63:0];
	endfunction

	function automatic longint point_coord(input longint base, input longint unsigned step,
			input logic [IDX_W-1:0] idx);
		longint unsigned span;
		span = step * idx;
		if (span > SPAN_CAP) span = SPAN_CAP;
		return clamp_coord(base + longint'(span));
	endfunction

	function automatic rsp_t expected_shade(input req_t px);
		longint cx, cy, zx, zy;
		longint unsigned ax, ay, sx, sy, cr, bound;
		int unsigned rounds, grey;
		logic esc;
		rsp_t shade;
		cx = point_coord(longint'(view_x0), longint'(pitch_x), px.col);
		cy = point_coord(longint'(view_y0), longint'(pitch_y), px.row);
		zx = cx;
		zy = cy;
		bound = ({61'd0, radius_q} * {61'd0, radius_q}) << FW;
		rounds = 0;
		esc = 1'b0;
		while (!esc && rounds < round_limit) begin
			ax = magnitude(zx);
			ay = magnitude(zy);
			sx = scaled_product(ax, ax, FW);
			sy = scaled_product(ay, ay, FW);
			if (sx + sy > bound) begin
				esc = 1'b1;
			end else begin
				cr = scaled_product(ax, ay, FW - 1);
				zx = clamp_coord(longint'(sx) - longint'(sy) + cx);
				zy = clamp_coord(longint'(cr) + cy);
				rounds++;
			end
		end
		grey = (round_limit == 0) ? 255 : (rounds * 255) / round_limit;
		shade.pixel = grey[PIX_W-1:0];
		shade.escape_count = rounds[ITER_W-1:0];
		shade.escaped = esc;
		return shade;
	endfunction

	// Leaves the write enable high so that back-to-back writes need no toggle.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CW-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			REG_X_MIN: view_x0 = data;
			REG_Y_MIN: view_y0 = data;
			REG_STEP_X: pitch_x = data[CW-2:0];
			REG_STEP_Y: pitch_y = data[CW-2:0];
			REG_RADIUS: radius_q = data[RAD_W-1:0];
			REG_MAX_ITERS: round_limit = data[ITER_W-1:0];
			default: ;
		endcase
	endtask

	task automatic setup(input longint xm, input longint ym, input longint sx,
			input longint sy, input longint rad, input longint iters);
		write_reg(REG_X_MIN, CW'(xm));
		write_reg(REG_Y_MIN, CW'(ym));
		write_reg(REG_STEP_X, CW'(sx));
		write_reg(REG_STEP_Y, CW'(sy));
		write_reg(REG_RADIUS, CW'(rad));
		write_reg(REG_MAX_ITERS, CW'(iters));
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	// Stops sending and waits until every pending pixel has come back.
	task automatic settle();
		req_valid <= 1'b0;
		while (shades_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Valid stays high after acceptance; it only drops for a gap or a settle.
	task automatic send_pixel(input logic [IDX_W-1:0] col, input logic [IDX_W-1:0] row);
		req_t px;
		int gap;
		px.col = col;
		px.row = row;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 10);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_beat <= px;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		shades_due.push_back(expected_shade(px));
	endtask

	function automatic logic [IDX_W-1:0] pick_index();
		case ($urandom_range(0, 15))
			0: return '0;
			1: return '1;
			default: return IDX_W'($urandom_range(0, 4095));
		endcase
	endfunction

	always @(posedge clk) begin
		if (!idle_on) begin
			rsp_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			rsp_stall <= 1'b1;
			stall_left <= $urandom_range(0, 9);
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	task automatic check_field(input string name, input logic [ITER_W-1:0] want,
			input logic [ITER_W-1:0] got);
		if (got !== want) begin
			errors++;
			if (errors <= 50)
				$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (shades_due.size() == 0) begin
				errors++;
				if (errors <= 50)
					$display("%0t: result beat with no pixel pending: expected none, actual %h",
						$time, rsp_beat);
			end else begin
				oldest = shades_due.pop_front();
				check_field("pixel", oldest.pixel, rsp_beat.pixel);
				check_field("escape_count", oldest.escape_count, rsp_beat.escape_count);
				check_field("escaped", oldest.escaped, rsp_beat.escaped);
				n_shaded++;
				if (oldest.escaped) n_escaped++;
				else n_capped++;
			end
		end
	end

	// Default view: column 512 and row 512 land on the origin, 768 on x = 1.
	task automatic test_reset_view();
		send_pixel(0, 0);
		send_pixel(512, 512);
		send_pixel(768, 512);
		send_pixel(4095, 4095);
		send_pixel(300, 900);
	endtask

	// Corners of the coordinate range, the span cap and bits above each width.
	task automatic test_coord_saturation();
		settle();
		setup(C_MAX, C_MIN, 36'hF_FFFF_FFFF, 0, 36'hA_AAAA_AAA9, 36'hF_0001_0004);
		send_pixel(4095, 0);
		send_pixel(0, 4095);
		send_pixel(1, 1);
		settle();
		setup(C_MIN, 0, 36'h7_FFFF_FFFF, 0, 2, 4);
		send_pixel(4095, 7);
		// One step lands a single LSB left of the origin, which never escapes.
		send_pixel(1, 100);
		send_pixel(0, 0);
	endtask

	task automatic test_radius_edges();
		settle();
		// With a zero radius only a nonzero floored magnitude escapes.
		setup(0, 0, 1 << 14, 1, 0, 6);
		send_pixel(0, 0);
		send_pixel(1, 0);
		send_pixel(0, 4095);
		settle();
		setup(0, 0, 1 << 18, 1 << 14, 7, 6);
		send_pixel(2048, 0);
		send_pixel(4095, 4095);
		send_pixel(100, 100);
	endtask

	task automatic test_iteration_limits();
		settle();
		setup(-2 * UNIT, -2 * UNIT, 1 << 20, 1 << 20, 2, 0);
		send_pixel(512, 512);
		send_pixel(0, 0);
		settle();
		setup(-2 * UNIT, -2 * UNIT, 1 << 20, 1 << 20, 2, 1);
		send_pixel(512, 512);
		send_pixel(0, 0);
		// The limit is hit with z already outside the radius.
		settle();
		setup(-2 * UNIT, -2 * UNIT, 1 << 20, 1 << 20, 2, 2);
		send_pixel(768, 512);
		settle();
		setup(-2 * UNIT, -2 * UNIT, 1 << 20, 1 << 20, 2, 65535);
		send_pixel(0, 0);
		send_pixel(768, 512);
	endtask

	task automatic test_spare_registers();
		settle();
		write_reg(CFG_SPARE_LO, 36'hF_FFFF_FFFF);
		write_reg(CFG_SPARE_HI, 36'h0);
		cfg_we <= 1'b0;
		send_pixel(768, 512);
		send_pixel(4095, 4095);
	endtask

	task automatic test_random_views();
		int sent, phase_items, k;
		longint xm, ym, sx, sy, rad, iters;
		logic drained;
		sent = 0;
		drained = 1'b0;
		while (sent < 740) begin
			settle();
			if ($urandom_range(0, 9) < 7) begin
				xm = -longint'($urandom_range(0, 32'd805306368));
				ym = -longint'($urandom_range(0, 32'd671088640));
				sx = $urandom_range(32'd4096, 32'd524288);
				sy = $urandom_range(32'd4096, 32'd524288);
			end else begin
				xm = {$urandom, $urandom};
				ym = {$urandom, $urandom};
				sx = {$urandom, $urandom};
				sy = {$urandom, $urandom};
			end
			rad = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 4) : $urandom_range(0, 7);
			k = $urandom_range(0, 19);
			if (k < 13) iters = $urandom_range(1, 40);
			else if (k < 16) iters = $urandom_range(41, 80);
			else if (k < 18) iters = $urandom_range(0, 3);
			else iters = $urandom_range(200, 300);
			phase_items = (iters > 80) ? 15 : $urandom_range(50, 90);
			setup(xm, ym, sx, sy, rad, iters);
			idle_on <= 1'b1;
			for (k = 0; k < phase_items; k++) begin
				send_pixel(pick_index(), pick_index());
				sent++;
				if (!drained && k == phase_items / 2) begin
					settle();
					drained = 1'b1;
				end
				if ($urandom_range(0, 39) == 0) idle_on <= !idle_on;
			end
		end
	endtask

	task automatic test_steady_stream();
		int k;
		settle();
		setup(-671088640, -2 * UNIT, 1 << 18, 196608, 2, 32);
		idle_on <= 1'b0;
		for (k = 0; k < 60; k++) send_pixel(pick_index(), pick_index());
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_reset_view();
		test_coord_saturation();
		test_radius_edges();
		test_iteration_limits();
		test_spare_registers();
		test_random_views();
		test_steady_stream();
		settle();
		repeat (40) @(posedge clk);
		$display("Checked %0d pixels over %0d register settings: %0d escaped, %0d hit the limit.",
			n_shaded, n_settings, n_escaped, n_capped);
		$display("Views ranged from saturated corners to fine steps, radius 0 to 7, limit 0 to 65535.");
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/bse_pkg.sv
rtl/core/bse_mul.sv
rtl/core/bse_div.sv
rtl/core/bse_dp.sv
rtl/core/bse_ctrl.sv
rtl/core/burning_ship_escape_time_core.sv
dv/tb_burning_ship_escape_time_core.sv
